// File: hw/rtl/aou_pkg.sv
// Shared types and constants for the Adam parameter update pipeline.
// No dependencies.
package aou_pkg;

	localparam int DEFAULT_FRACTION_BITS = 24;
	localparam int DECAY_BITS = 24;
	localparam int WORD_BITS = 32;

	localparam logic [31:0] STEP_SIZE_RST = 32'd1678;
	localparam logic [23:0] FIRST_DECAY_RST = 24'd15099494;
	localparam logic [23:0] SECOND_DECAY_RST = 24'd16760438;
	localparam logic [23:0] EPSILON_RST = 24'd1;

	localparam logic [1:0] REG_STEP_SIZE = 2'd0;
	localparam logic [1:0] REG_FIRST_DECAY = 2'd1;
	localparam logic [1:0] REG_SECOND_DECAY = 2'd2;
	localparam logic [1:0] REG_EPSILON = 2'd3;

	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] nm;
		logic [31:0] nv;
		logic neg;
		logic last;
	} side_t;

endpackage

// File: hw/rtl/aou_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on aou_pkg.
module aou_sqrt import aou_pkg::*; #(
	parameter int RW = 56,
	parameter int PW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input logic [RW-1:0] rad,
	input logic [PW-1:0] side_in,
	output logic vout,
	output logic [(RW+1)/2-1:0] root,
	output logic [PW-1:0] side_out
);

	localparam int NR = (RW + 1) / 2;
	localparam int RW2 = 2 * NR;
	localparam int RMW = NR + 3;

	logic [RW2-1:0] rad_s [0:NR];
	logic [RMW-1:0] rem_s [0:NR];
	logic [NR-1:0] root_s [0:NR];
	logic [PW-1:0] side_s [0:NR];
	logic vld_s [0:NR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0] <= RW2'(rad);
			rem_s[0] <= '0;
			root_s[0] <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < NR; k++) begin : g_stage
		logic [RMW-1:0] sh;
		logic [RMW-1:0] trial;
		logic fit;

		always_comb begin
			sh = {rem_s[k][RMW-3:0], rad_s[k][RW2-1:RW2-2]};
			trial = RMW'({root_s[k], 2'b01});
			fit = (sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= {rad_s[k][RW2-3:0], 2'b00};
				rem_s[k+1] <= fit ? sh - trial : sh;
				root_s[k+1] <= {root_s[k][NR-2:0], fit};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vout = vld_s[NR];
	assign root = root_s[NR];
	assign side_out = side_s[NR];

endmodule

// File: hw/rtl/aou_div.sv
// Pipelined 64/32 divider with a quotient capped at 2^32, one bit per stage.
// Depends on aou_pkg.
module aou_div import aou_pkg::*; #(
	parameter int PW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input logic [63:0] num,
	input logic [31:0] den,
	input logic [PW-1:0] side_in,
	output logic vout,
	output logic [32:0] quo,
	output logic [PW-1:0] side_out
);

	localparam int NS = 32;

	logic [32:0] rem_s [0:NS];
	logic [31:0] quo_s [0:NS];
	logic [31:0] den_s [0:NS];
	logic cap_s [0:NS];
	logic zero_s [0:NS];
	logic [PW-1:0] side_s [0:NS];
	logic vld_s [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num[63:32]};
			quo_s[0] <= num[31:0];
			den_s[0] <= den;
			cap_s[0] <= (num[63:32] >= den);
			zero_s[0] <= (num == 64'd0);
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [32:0] sh;
		logic fit;

		always_comb begin
			sh = {rem_s[k][31:0], quo_s[k][31]};
			fit = (sh >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fit ? sh - {1'b0, den_s[k]} : sh;
				quo_s[k+1] <= {quo_s[k][30:0], fit};
				den_s[k+1] <= den_s[k];
				cap_s[k+1] <= cap_s[k];
				zero_s[k+1] <= zero_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_comb begin
		if (zero_s[NS]) begin
			quo = '0;
		end else if (cap_s[NS]) begin
			quo = {1'b1, 32'd0};
		end else begin
			quo = {1'b0, quo_s[NS]};
		end
	end

	assign vout = vld_s[NS];
	assign side_out = side_s[NS];

endmodule

// File: hw/rtl/adam_optimizer_update_top.sv
// Adam parameter update: moment, velocity and parameter step in fixed point.
// Depends on aou_pkg, aou_sqrt, aou_div.
//
// Usage:
//  s_axis carries one parameter per transfer; tlast marks the last element of
//  a node vector and comes back on m_axis tlast with the matching result.
//  m_axis returns the new parameter, first moment and second moment.
//  The cfg port writes step_size, first_decay, second_decay and epsilon;
//  write only while no transfer is in flight.
// Throughput: one transfer per cycle while m_axis does not stall.
// Pipeline from s_axis to m_axis: four arithmetic stages, the input register
//  and one stage per root bit of the square root, the input register and
//  one stage per quotient bit of the 32-step divider, plus the denominator
//  and output stages.
// Reset: all valid bits clear, the cfg registers take their default values.
// Stall: while m_axis holds a result that is not taken, the whole pipeline
//  freezes and s_axis_tready is low; nothing is dropped or repeated.
module adam_optimizer_update_top import aou_pkg::*; #(
	parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// parameter_req[31:0], gradient[63:32], moment[95:64], velocity[127:96]
	input logic [127:0] s_axis_tdata,
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// new_parameter[31:0], new_moment[63:32], new_velocity[95:64]
	output logic [95:0] m_axis_tdata,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int RW = WORD_BITS + FRACTION_BITS;
	localparam int NR = (RW + 1) / 2;
	localparam int SPW = 64 + $bits(side_t);

	logic en;
	logic [31:0] step_size_q;
	logic [23:0] first_decay_q;
	logic [23:0] second_decay_q;
	logic [23:0] epsilon_q;

	assign en = m_axis_tready | ~m_axis_tvalid;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RST;
			first_decay_q <= FIRST_DECAY_RST;
			second_decay_q <= SECOND_DECAY_RST;
			epsilon_q <= EPSILON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_SIZE: step_size_q <= cfg_data;
				REG_FIRST_DECAY: first_decay_q <= cfg_data[23:0];
				REG_SECOND_DECAY: second_decay_q <= cfg_data[23:0];
				REG_EPSILON: epsilon_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// stage 1: first-moment products and gradient square
	logic signed [25:0] b1;
	logic signed [25:0] c1;
	logic signed [57:0] ma_s1, mg_s1;
	logic signed [63:0] gg_s1;
	logic signed [31:0] p_s1;
	logic [31:0] v_s1;
	logic last_s1, vld_s1;

	assign b1 = {2'b00, first_decay_q};
	assign c1 = 26'sd16777216 - b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= b1 * $signed(s_axis_tdata[95:64]);
			mg_s1 <= c1 * $signed(s_axis_tdata[63:32]);
			gg_s1 <= $signed(s_axis_tdata[63:32]) * $signed(s_axis_tdata[63:32]);
			p_s1 <= $signed(s_axis_tdata[31:0]);
			v_s1 <= s_axis_tdata[127:96];
			last_s1 <= s_axis_tlast;
		end
	end

	// stage 2: new moment, scaled gradient square
	logic signed [59:0] msum, msh;
	logic [63:0] gsh;
	logic signed [31:0] nm_s2, p_s2;
	logic [31:0] gsq_s2, v_s2;
	logic last_s2, vld_s2;

	always_comb begin
		msum = 60'(ma_s1) + 60'(mg_s1) + 60'sd8388608;
		msh = msum >>> DECAY_BITS;
		gsh = gg_s1 >> FRACTION_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (msh > 60'sd2147483647) begin
				nm_s2 <= 32'sh7fffffff;
			end else if (msh < -60'sd2147483648) begin
				nm_s2 <= 32'sh80000000;
			end else begin
				nm_s2 <= msh[31:0];
			end
			gsq_s2 <= (|gsh[63:32]) ? 32'hffffffff : gsh[31:0];
			p_s2 <= p_s1;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: velocity products, moment magnitude
	logic [24:0] c2;
	logic [55:0] pva_s3;
	logic [56:0] pvb_s3;
	logic [31:0] mmag_s3;
	logic signed [31:0] nm_s3, p_s3;
	logic neg_s3, last_s3, vld_s3;

	assign c2 = 25'd16777216 - {1'b0, second_decay_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pva_s3 <= 56'(second_decay_q) * 56'(v_s2);
			pvb_s3 <= 57'(c2) * 57'(gsq_s2);
			mmag_s3 <= nm_s2[31] ? 32'(-nm_s2) : nm_s2;
			neg_s3 <= nm_s2[31];
			nm_s3 <= nm_s2;
			p_s3 <= p_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: new velocity, numerator
	logic [57:0] vsum;
	logic [33:0] vsh;
	logic [31:0] nv_s4;
	logic [63:0] num_s4;
	side_t side_s4;
	logic vld_s4;

	always_comb begin
		vsum = 58'(pva_s3) + 58'(pvb_s3) + 58'd8388608;
		vsh = vsum[57:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nv_s4 <= (|vsh[33:32]) ? 32'hffffffff : vsh[31:0];
			num_s4 <= 64'(step_size_q) * 64'(mmag_s3);
			side_s4.p <= p_s3;
			side_s4.nm <= nm_s3;
			side_s4.neg <= neg_s3;
			side_s4.last <= last_s3;
			side_s4.nv <= '0;
		end
	end

	side_t side_sq_in;
	always_comb begin
		side_sq_in = side_s4;
		side_sq_in.nv = nv_s4;
	end

	logic sq_vld;
	logic [NR-1:0] sq_root;
	logic [SPW-1:0] sq_side;

	aou_sqrt #(
		.RW(RW),
		.PW(SPW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(vld_s4),
		.rad({nv_s4, {FRACTION_BITS{1'b0}}}),
		.side_in({num_s4, side_sq_in}),
		.vout(sq_vld),
		.root(sq_root),
		.side_out(sq_side)
	);

	// stage 5: denominator
	logic [31:0] den_s5;
	logic [63:0] num_s5;
	side_t side_s5;
	logic vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= 32'(sq_root) + {8'd0, epsilon_q};
			num_s5 <= sq_side[SPW-1:SPW-64];
			side_s5 <= side_t'(sq_side[$bits(side_t)-1:0]);
		end
	end

	logic dv_vld;
	logic [32:0] dv_quo;
	side_t dv_side;

	aou_div #(
		.PW($bits(side_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(vld_s5),
		.num(num_s5),
		.den(den_s5),
		.side_in(side_s5),
		.vout(dv_vld),
		.quo(dv_quo),
		.side_out(dv_side)
	);

	// output stage: apply step, saturate
	logic signed [34:0] np;
	always_comb begin
		if (dv_side.neg) begin
			np = 35'(dv_side.p) - $signed({2'b00, dv_quo});
		end else begin
			np = 35'(dv_side.p) + $signed({2'b00, dv_quo});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (np > 35'sd2147483647) begin
				m_axis_tdata[31:0] <= 32'h7fffffff;
			end else if (np < -35'sd2147483648) begin
				m_axis_tdata[31:0] <= 32'h80000000;
			end else begin
				m_axis_tdata[31:0] <= np[31:0];
			end
			m_axis_tdata[63:32] <= dv_side.nm;
			m_axis_tdata[95:64] <= dv_side.nv;
			m_axis_tlast <= dv_side.last;
		end
	end

`ifndef NO_ASSERTIONS
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (m_axis_tready || !m_axis_tvalid))
		else $error("input ready does not follow output stall");
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s5))
		else $error("pipeline moved during stall");
	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv_vld |=> m_axis_tvalid)
		else $error("divider result lost");
`endif

endmodule
